// ----- hdl/tsrt_pkg.sv -----
// Shared types and constants for the trailing-stop reference tracker.
`default_nettype none

package tsrt_pkg;

    localparam int PRICE_W = 32;
    localparam int IN_INDEX_W = 8;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * PRICE_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [FRAC_W-1:0] START_RESET = 16'd3277;
    localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;
    localparam logic [PRICE_W-1:0] PRICE_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_CHOOSE,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic rd_mem;
        logic mul_ref;
        logic div_init;
        logic div_step;
        logic choose;
        logic mul_scale;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic first;
        logic div_last;
        logic need_scale;
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic sold;
        logic [PRICE_W-1:0] reference;
        logic [PRICE_W-1:0] prev_close;
    } entry_t;

endpackage

`default_nettype wire

// ----- hdl/tsrt_ctrl.sv -----
// Controller state machine that sequences one word through the datapath.
`default_nettype none

module tsrt_ctrl
    import tsrt_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_mem = 1'b1;
                state_next = stat.first ? ST_CHOOSE : ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_ref = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_CHOOSE;
                end
            end
            ST_CHOOSE: begin
                cmd.choose = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.mul_scale = stat.need_scale;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/tsrt_datapath.sv -----
// Datapath with the series store, shared multiplier, divider and output register.
`default_nettype none

module tsrt_datapath
    import tsrt_pkg::*;
#(
    parameter int NUM_SERIES = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    input  wire logic [39:0]          s_tdata,
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [39:0]               m_tdata,
    output logic                      m_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [FRAC_W-1:0]    cfg_data
);

    localparam int IDX_W = (NUM_SERIES > 1) ? $clog2(NUM_SERIES) : 1;
    localparam int MOD_W = 21;

    logic [FRAC_W-1:0]     start_reg;
    logic [IN_INDEX_W-1:0] idx_reg;
    logic [PRICE_W-1:0]    close_reg;
    logic                  first_reg;
    entry_t                rd_reg;
    entry_t                wr_entry;
    entry_t                mem [NUM_SERIES];
    logic [IDX_W-1:0]      addr;
    logic [MOD_W-1:0]      mod_val;
    logic [PROD_W-1:0]     prod_reg;
    logic [PRICE_W-1:0]    rem_reg;
    logic [PRICE_W-1:0]    quo_reg;
    logic                  ovf_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [PRICE_W:0]      div_trial;
    logic                  div_ge;
    logic [PRICE_W:0]      div_diff;
    logic [PRICE_W-1:0]    cand;
    logic [PRICE_W-1:0]    ratchet;
    logic [PRICE_W-1:0]    ref_reg;
    logic [PRICE_W-1:0]    ref_next;
    logic                  sold_reg;
    logic                  sold_next;
    logic                  scale_reg;
    logic                  scale_next;
    logic                  up_reg;
    logic                  up_next;
    logic [FRAC_W:0]       factor;
    logic [PRICE_W-1:0]    final_ref;
    logic                  m_tvalid_reg;
    logic [39:0]           m_tdata_reg;
    logic                  m_tuser_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_RESET;
        end else if (cfg_valid) begin
            start_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            idx_reg <= s_tdata[7:0];
            close_reg <= s_tdata[39:8];
            first_reg <= s_tuser;
        end
    end

    // Series index modulo NUM_SERIES by restoring subtraction of shifted constants.
    always_comb begin
        mod_val = MOD_W'(idx_reg);
        for (int k = 7; k >= 0; k--) begin
            if (mod_val >= (MOD_W'(NUM_SERIES) << k)) begin
                mod_val = mod_val - (MOD_W'(NUM_SERIES) << k);
            end
        end
        addr = mod_val[IDX_W-1:0];
    end

    assign wr_entry = '{sold: sold_reg, reference: final_ref, prev_close: close_reg};

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            mem[addr] <= wr_entry;
        end
        if (cmd.rd_mem) begin
            rd_reg <= mem[addr];
        end
    end

    assign factor = up_reg ? (FRAC_ONE + {1'b0, start_reg}) : (FRAC_ONE - {1'b0, start_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mul_ref) begin
            prod_reg <= PROD_W'(rd_reg.reference) * PROD_W'(close_reg);
        end else if (cmd.mul_scale) begin
            prod_reg <= PROD_W'(close_reg) * PROD_W'(factor);
        end
    end

    // One quotient bit per cycle; the quotient fits in 32 bits unless overflow was flagged.
    assign div_trial = {rem_reg, quo_reg[PRICE_W-1]};
    assign div_ge = div_trial >= {1'b0, rd_reg.prev_close};
    assign div_diff = div_trial - {1'b0, rd_reg.prev_close};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_init) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= prod_reg[PROD_W-1:PRICE_W];
            quo_reg <= prod_reg[PRICE_W-1:0];
            ovf_reg <= prod_reg[PROD_W-1:PRICE_W] >= rd_reg.prev_close;
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? div_diff[PRICE_W-1:0] : div_trial[PRICE_W-1:0];
            quo_reg <= {quo_reg[PRICE_W-2:0], div_ge};
        end
    end

    always_comb begin
        if (rd_reg.prev_close == '0) begin
            cand = rd_reg.reference;
        end else if (ovf_reg) begin
            cand = PRICE_MAX;
        end else begin
            cand = quo_reg;
        end
        ratchet = cand;
        ref_next = cand;
        sold_next = 1'b0;
        scale_next = 1'b1;
        up_next = 1'b0;
        if (!first_reg) begin
            if (rd_reg.sold) begin
                ratchet = (cand > rd_reg.reference) ? rd_reg.reference : cand;
                if (close_reg > ratchet) begin
                    sold_next = 1'b0;
                    scale_next = 1'b1;
                end else begin
                    sold_next = 1'b1;
                    scale_next = 1'b0;
                end
            end else begin
                ratchet = (cand < rd_reg.reference) ? rd_reg.reference : cand;
                if (close_reg < ratchet) begin
                    sold_next = 1'b1;
                    scale_next = 1'b1;
                    up_next = 1'b1;
                end else begin
                    sold_next = 1'b0;
                    scale_next = 1'b0;
                end
            end
            ref_next = ratchet;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.choose) begin
            ref_reg <= ref_next;
            sold_reg <= sold_next;
            scale_reg <= scale_next;
            up_reg <= up_next;
        end
    end

    always_comb begin
        if (!scale_reg) begin
            final_ref = ref_reg;
        end else if (prod_reg[PROD_W-1:48] != '0) begin
            final_ref = PRICE_MAX;
        end else begin
            final_ref = prod_reg[47:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= {final_ref, idx_reg};
            m_tuser_reg <= sold_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    assign stat.first = first_reg;
    assign stat.div_last = cnt_reg == DIV_CNT_W'(PRICE_W - 1);
    assign stat.need_scale = scale_reg;
    assign stat.out_busy = m_tvalid_reg && !m_tready;

`ifndef SYNTHESIS
    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> !cmd.load_in)
        else $error("second word accepted while one is in progress");

    a_div_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.choose && !first_reg |-> cnt_reg == '0)
        else $error("decision taken before the division finished");

    a_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid && m_tuser == $past(sold_reg))
        else $error("result word not loaded with the new state");

    a_result_index: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tdata[7:0] == $past(idx_reg))
        else $error("result word carries the wrong series index");
`endif

endmodule

`default_nettype wire

// ----- hdl/trailing_stop_reference_tracker.sv -----
// Top level of the trailing-stop reference tracker.
//
// Each input word carries a series index and a close price; tuser marks the
// first day of that series. The block answers every input word with exactly one
// result word: the series index, the new trailing-stop reference and the sold
// flag after this close. The cfg channel writes the start fraction and is always
// ready; the user must write it only while no word is in progress, as the block
// does not enforce this. A first-day word passes through the read, choose, scale
// and done states. Any other word also runs a multiply and a 64-by-32 bit
// division at one quotient bit per cycle between the read and the choice.
// Words are worked on one at a time. A finished result sits in the output
// register, so the block accepts the next word while the receiver stalls; if
// the register is still full when the next result is ready, the block waits.
// Reset clears the control logic and restores the start fraction; the series
// store is not cleared, and each series must first see a first-day word.
`default_nettype none

module trailing_stop_reference_tracker
    import tsrt_pkg::*;
#(
    parameter int NUM_SERIES = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,   // series_index, close_price
    input  wire logic              s_tuser,   // first_day
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,   // series_echo, reference_price
    output logic                   m_tuser,   // sold_flag
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [FRAC_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tsrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsrt_datapath #(
        .NUM_SERIES (NUM_SERIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ----- tb/trailing_stop_reference_tracker_tb.sv -----
// Self-checking testbench for the trailing-stop reference tracker with random flow control.
`timescale 1ns / 100ps

module trailing_stop_reference_tracker_tb;
    import tsrt_pkg::*;

    localparam int SERIES_COUNT = 256;
    localparam int HALF_PERIOD = 10;
    localparam int WORDS_PER_PHASE = 200;
    localparam int LONG_HOLD = 400;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic [IN_INDEX_W-1:0] series;
        logic [PRICE_W-1:0]    stop_px;
        logic                  sold;
    } stop_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [FRAC_W-1:0]     cfg_data = '0;

    logic [FRAC_W-1:0]     band_frac = START_RESET;
    logic                  sold_mark [SERIES_COUNT];
    logic [PRICE_W-1:0]    stop_px_mem [SERIES_COUNT];
    logic [PRICE_W-1:0]    last_close_mem [SERIES_COUNT];
    stop_result_t          pending_stops [$];

    bit                    seeded [SERIES_COUNT];
    logic [PRICE_W-1:0]    walk_px [SERIES_COUNT];

    int errors = 0;
    int words_taken = 0;
    int first_days = 0;
    int results_seen = 0;
    int sold_results = 0;
    int settings_used = 0;
    int burst_left = 0;
    int hold_asked = 0;
    int hold_done = 0;
    int hold_left = 0;
    int rx_mode = 0;
    int mode_left = 0;
    int rx_phase = 0;

    trailing_stop_reference_tracker #(
        .NUM_SERIES(SERIES_COUNT)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [PRICE_W-1:0] clip_price(input logic [PROD_W-1:0] v);
        return (v > {32'd0, PRICE_MAX}) ? PRICE_MAX : v[PRICE_W-1:0];
    endfunction

    function automatic logic [PRICE_W-1:0] band_price(input logic [PRICE_W-1:0] close,
                                                      input logic widen);
        logic [PROD_W-1:0] factor;
        factor = widen ? (64'd65536 + band_frac) : (64'd65536 - band_frac);
        return clip_price(({32'd0, close} * factor) >> FRAC_W);
    endfunction

    function automatic stop_result_t advance_stop(input logic [IN_INDEX_W-1:0] idx,
                                                  input logic [PRICE_W-1:0] close,
                                                  input logic first);
        stop_result_t r;
        logic [PRICE_W-1:0] held;
        logic [PRICE_W-1:0] cand;
        int s;
        s = idx % SERIES_COUNT;
        r.series = idx;
        if (first) begin
            r.stop_px = band_price(close, 1'b0);
            r.sold = 1'b0;
        end else begin
            held = stop_px_mem[s];
            r.sold = sold_mark[s];
            if (last_close_mem[s] == '0) begin
                cand = held;
            end else begin
                cand = clip_price(({32'd0, held} * {32'd0, close}) / {32'd0, last_close_mem[s]});
            end
            if (r.sold) begin
                if (cand > held) begin
                    cand = held;
                end
                if (close > cand) begin
                    r.sold = 1'b0;
                    r.stop_px = band_price(close, 1'b0);
                end else begin
                    r.stop_px = cand;
                end
            end else begin
                if (cand < held) begin
                    cand = held;
                end
                if (close < cand) begin
                    r.sold = 1'b1;
                    r.stop_px = band_price(close, 1'b1);
                end else begin
                    r.stop_px = cand;
                end
            end
        end
        sold_mark[s] = r.sold;
        stop_px_mem[s] = r.stop_px;
        last_close_mem[s] = close;
        return r;
    endfunction

    always @(posedge aclk) begin
        stop_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_stops.size() == 0) begin
                    $display("%0t: unexpected result word, got series %0d reference %h sold %b",
                             $time, m_tdata[7:0], m_tdata[39:8], m_tuser);
                    errors++;
                end else begin
                    want = pending_stops.pop_front();
                    if (m_tdata[7:0] !== want.series) begin
                        $display("%0t: series_echo expected %0d, got %0d",
                                 $time, want.series, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[39:8] !== want.stop_px) begin
                        $display("%0t: reference_price expected %h, got %h",
                                 $time, want.stop_px, m_tdata[39:8]);
                        errors++;
                    end
                    if (m_tuser !== want.sold) begin
                        $display("%0t: sold_flag expected %b, got %b",
                                 $time, want.sold, m_tuser);
                        errors++;
                    end
                    results_seen++;
                    if (want.sold) begin
                        sold_results++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_stops.push_back(advance_stop(s_tdata[7:0], s_tdata[39:8], s_tuser));
                words_taken++;
                if (s_tuser) begin
                    first_days++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                band_frac = cfg_data;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_done != hold_asked) begin
            hold_done = hold_asked;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            rx_phase = (rx_phase + 1) % 3;
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 9) >= 4);
                end
                default: begin
                    m_tready <= (rx_phase == 0);
                end
            endcase
        end
    end

    task automatic send_word(input logic [IN_INDEX_W-1:0] idx, input logic [PRICE_W-1:0] close,
                             input logic first);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        seeded[idx] = 1'b1;
        walk_px[idx] = close;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {close, idx};
        s_tuser <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random_word();
        logic [IN_INDEX_W-1:0] idx;
        logic [PRICE_W-1:0] close;
        logic [PRICE_W-1:0] step;
        logic first;
        int pick;
        if ($urandom_range(0, 6) == 0) begin
            idx = 8'($urandom_range(0, 255));
        end else begin
            idx = 8'($urandom_range(0, 15));
        end
        first = !seeded[idx] || ($urandom_range(0, 39) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            close = '0;
        end else if (pick < 8) begin
            close = PRICE_MAX;
        end else if (pick < 18) begin
            close = $urandom;
        end else if (pick < 24) begin
            close = $urandom_range(0, 255);
        end else if (first) begin
            close = $urandom_range(32'h0000_8000, 32'h0400_0000);
        end else begin
            step = (walk_px[idx] >> $urandom_range(2, 7)) + $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 1) begin
                if ({1'b0, walk_px[idx]} + {1'b0, step} > {1'b0, PRICE_MAX}) begin
                    close = PRICE_MAX;
                end else begin
                    close = walk_px[idx] + step;
                end
            end else begin
                close = (step > walk_px[idx]) ? '0 : walk_px[idx] - step;
            end
        end
        send_word(idx, close, first);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_stops.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_band(input logic [FRAC_W-1:0] frac);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= frac;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic test_reset_band();
        send_word(8'd0, 32'h0000_0000, 1'b1);
        send_word(8'd255, PRICE_MAX, 1'b1);
        send_word(8'd0, 32'h0001_0000, 1'b0);
        send_word(8'd255, 32'h0000_0001, 1'b0);
        send_word(8'd255, PRICE_MAX, 1'b0);
        send_word(8'd7, 32'h0001_0000, 1'b1);
        send_word(8'd7, 32'h0000_0100, 1'b0);
        send_word(8'd7, PRICE_MAX, 1'b0);
        send_word(8'd9, 32'h0001_0000, 1'b1);
        send_word(8'd9, 32'h0000_0000, 1'b0);
        send_word(8'd9, 32'h0000_0000, 1'b0);
        send_word(8'd9, 32'h0002_0000, 1'b0);
        drain_results();
    endtask

    task automatic test_zero_band();
        write_band(16'h0000);
        send_word(8'd3, 32'h0001_2345, 1'b1);
        send_word(8'd3, 32'h0001_2345, 1'b0);
        send_word(8'd3, 32'h0002_0000, 1'b0);
        send_word(8'd3, 32'h0001_FFFF, 1'b0);
        send_word(8'd20, PRICE_MAX, 1'b1);
        drain_results();
    endtask

    task automatic test_full_band();
        write_band(16'hFFFF);
        send_word(8'd20, 32'hFFFF_0000, 1'b0);
        send_word(8'd21, PRICE_MAX, 1'b1);
        send_word(8'd21, 32'h0000_0001, 1'b0);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        hold_asked++;
        burst_left = 40;
        repeat (12) send_random_word();
        drain_results();
        repeat (8) send_random_word();
        drain_results();
    endtask

    task automatic test_random_band(input logic [FRAC_W-1:0] frac);
        write_band(frac);
        repeat (WORDS_PER_PHASE) send_random_word();
        drain_results();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_band();
        test_zero_band();
        test_full_band();
        test_output_backpressure();
        test_random_band(START_RESET);
        test_random_band(16'($urandom));
        test_random_band(16'hFFFF);
        test_random_band(16'($urandom));
        test_random_band(16'h0000);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_stops.size() != 0) begin
            $display("%0t: %0d expected result words never arrived",
                     $time, pending_stops.size());
            errors++;
        end
        $display("Checked %0d result words against %0d input words, %0d of them first-day words.",
                 results_seen, words_taken, first_days);
        $display("Used %0d start-fraction writes incl. 0 and 65535; %0d sold results; %0d-cycle hold.",
                 settings_used, sold_results, LONG_HOLD);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout with %0d result words outstanding", $time, pending_stops.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
